// ===== hdl/dlm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlm_pkg
// Shared types and constants for the fully connected layer engine.
// ----------------------------------------------------------------------------
package dlm_pkg;

  localparam int MAX_IN     = 1024;
  localparam int MAX_OUT    = 64;
  localparam int FRAC_BITS  = 12;

  localparam int VAL_W      = 16;
  localparam int ROW_W      = $clog2(MAX_OUT);
  localparam int COL_W      = $clog2(MAX_IN);
  localparam int W_ADDR_W   = ROW_W + COL_W;
  localparam int W_DEPTH    = MAX_OUT * MAX_IN;
  localparam int IN_SIZE_W  = 11;
  localparam int OUT_SIZE_W = 7;
  localparam int PROD_W     = 2 * VAL_W;
  localparam int ACC_W      = 48;
  localparam int CFG_W      = IN_SIZE_W;
  localparam int CFG_IDX_W  = 1;

  localparam logic [IN_SIZE_W-1:0]  IN_SIZE_RST  = IN_SIZE_W'(1024);
  localparam logic [OUT_SIZE_W-1:0] OUT_SIZE_RST = OUT_SIZE_W'(64);
  localparam logic [IN_SIZE_W-1:0]  N_IN_MAX     = IN_SIZE_W'(MAX_IN);
  localparam logic [OUT_SIZE_W-1:0] N_OUT_MAX    = OUT_SIZE_W'(MAX_OUT);

  localparam logic [CFG_IDX_W-1:0] CFG_IN_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_SIZE = 1'b1;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] Q_MAX      = ACC_W'((1 << (VAL_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] Q_MIN      = ACC_W'(-(1 << (VAL_W - 1)));

  typedef enum logic [1:0] {
    CMD_WEIGHT = 2'd0,
    CMD_BIAS   = 2'd1,
    CMD_INPUT  = 2'd2,
    CMD_RUN    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW,
    S_MAC,
    S_DRAIN,
    S_EMIT
  } state_t;

  typedef struct packed {
    cmd_t                    command;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        column;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [ROW_W-1:0]        out_index;
    logic signed [VAL_W-1:0] out_value;
    logic                    saturated;
    logic                    last;
  } out_word_t;

  typedef struct packed {
    logic             load;
    logic             acc_clr;
    logic             mac_issue;
    logic             emit;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_empty;
  } dp_stat_t;

endpackage

// ===== hdl/dlm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlm_ram
// Generic simple dual-port RAM, one write port, registered read port.
// ----------------------------------------------------------------------------
module dlm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/dlm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlm_ctrl
// Sequencer: accepts command words, walks rows and columns of a run.
// ----------------------------------------------------------------------------
module dlm_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  dlm_pkg::cmd_t                    command,
  input  logic [dlm_pkg::IN_SIZE_W-1:0]    in_size,
  input  logic [dlm_pkg::OUT_SIZE_W-1:0]   out_size,
  input  dlm_pkg::dp_stat_t                stat,
  output dlm_pkg::dp_cmd_t                 cmd,
  output logic                             busy
);

  dlm_pkg::state_t                   state_r, state_nxt;
  logic [dlm_pkg::ROW_W-1:0]         row_r, row_nxt;
  logic [dlm_pkg::COL_W-1:0]         col_r, col_nxt;
  logic [dlm_pkg::IN_SIZE_W-1:0]     n_in_r, n_in_nxt;
  logic [dlm_pkg::OUT_SIZE_W-1:0]    n_out_r, n_out_nxt;
  logic [dlm_pkg::IN_SIZE_W-1:0]     n_in_clamp;
  logic [dlm_pkg::OUT_SIZE_W-1:0]    n_out_clamp;
  logic                              col_last;
  logic                              row_last;

  assign n_in_clamp  = (in_size > dlm_pkg::N_IN_MAX) ? dlm_pkg::N_IN_MAX : in_size;
  assign n_out_clamp = (out_size > dlm_pkg::N_OUT_MAX) ? dlm_pkg::N_OUT_MAX : out_size;
  assign col_last = (dlm_pkg::IN_SIZE_W'(col_r) + dlm_pkg::IN_SIZE_W'(1)) == n_in_r;
  assign row_last = (dlm_pkg::OUT_SIZE_W'(row_r) + dlm_pkg::OUT_SIZE_W'(1)) == n_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dlm_pkg::S_IDLE;
      row_r   <= '0;
      col_r   <= '0;
      n_in_r  <= '0;
      n_out_r <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      n_in_r  <= n_in_nxt;
      n_out_r <= n_out_nxt;
    end
  end

  // next state and counters
  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    n_in_nxt  = n_in_r;
    n_out_nxt = n_out_r;
    unique case (state_r)
      dlm_pkg::S_IDLE: begin
        if (start && command == dlm_pkg::CMD_RUN && n_out_clamp != '0) begin
          n_in_nxt  = n_in_clamp;
          n_out_nxt = n_out_clamp;
          row_nxt   = '0;
          state_nxt = dlm_pkg::S_ROW;
        end
      end
      dlm_pkg::S_ROW: begin
        col_nxt   = '0;
        state_nxt = (n_in_r == '0) ? dlm_pkg::S_DRAIN : dlm_pkg::S_MAC;
      end
      dlm_pkg::S_MAC: begin
        col_nxt = col_r + dlm_pkg::COL_W'(1);
        if (col_last) begin
          state_nxt = dlm_pkg::S_DRAIN;
        end
      end
      dlm_pkg::S_DRAIN: begin
        if (stat.pipe_empty) begin
          state_nxt = dlm_pkg::S_EMIT;
        end
      end
      dlm_pkg::S_EMIT: begin
        if (row_last) begin
          state_nxt = dlm_pkg::S_IDLE;
        end else begin
          row_nxt   = row_r + dlm_pkg::ROW_W'(1);
          state_nxt = dlm_pkg::S_ROW;
        end
      end
      default: state_nxt = dlm_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy          = (state_r != dlm_pkg::S_IDLE);
    cmd           = '0;
    cmd.row       = row_r;
    cmd.col       = col_r;
    cmd.last      = row_last;
    cmd.load      = start && !busy && command != dlm_pkg::CMD_RUN;
    cmd.acc_clr   = (state_r == dlm_pkg::S_ROW);
    cmd.mac_issue = (state_r == dlm_pkg::S_MAC);
    cmd.emit      = (state_r == dlm_pkg::S_EMIT);
  end

endmodule

// ===== hdl/dlm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlm_dp
// Datapath: weight, bias and input stores, MAC pipeline, round and saturate.
// ----------------------------------------------------------------------------
module dlm_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  dlm_pkg::in_word_t   in_word,
  input  dlm_pkg::dp_cmd_t    cmd,
  output dlm_pkg::dp_stat_t   stat,
  output logic                out_valid,
  output dlm_pkg::out_word_t  out_word
);

  logic [dlm_pkg::VAL_W-1:0]         w_rdata;
  logic [dlm_pkg::VAL_W-1:0]         x_rdata;
  logic [dlm_pkg::VAL_W-1:0]         b_rdata;
  logic                              w_we, b_we, x_we;
  logic                              rd_valid_r;
  logic                              prod_valid_r;
  logic signed [dlm_pkg::PROD_W-1:0] prod_r;
  logic signed [dlm_pkg::ACC_W-1:0]  acc_r;
  logic signed [dlm_pkg::ACC_W-1:0]  bias_ext;
  logic signed [dlm_pkg::ACC_W-1:0]  total;
  logic signed [dlm_pkg::ACC_W-1:0]  q;
  logic                              sat_hi, sat_lo;
  logic                              out_valid_r;
  dlm_pkg::out_word_t                out_word_r, out_word_nxt;

  assign w_we = cmd.load && in_word.command == dlm_pkg::CMD_WEIGHT;
  assign b_we = cmd.load && in_word.command == dlm_pkg::CMD_BIAS;
  assign x_we = cmd.load && in_word.command == dlm_pkg::CMD_INPUT;

  dlm_ram #(.WIDTH(dlm_pkg::VAL_W), .DEPTH(dlm_pkg::W_DEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr ({in_word.row, in_word.column}),
    .wdata (in_word.value),
    .raddr ({cmd.row, cmd.col}),
    .rdata (w_rdata)
  );

  dlm_ram #(.WIDTH(dlm_pkg::VAL_W), .DEPTH(dlm_pkg::MAX_IN)) u_input_ram (
    .clk   (clk),
    .we    (x_we),
    .waddr (in_word.column),
    .wdata (in_word.value),
    .raddr (cmd.col),
    .rdata (x_rdata)
  );

  dlm_ram #(.WIDTH(dlm_pkg::VAL_W), .DEPTH(dlm_pkg::MAX_OUT)) u_bias_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (in_word.row),
    .wdata (in_word.value),
    .raddr (cmd.row),
    .rdata (b_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r   <= 1'b0;
      prod_valid_r <= 1'b0;
      acc_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      rd_valid_r   <= cmd.mac_issue;
      prod_valid_r <= rd_valid_r;
      out_valid_r  <= cmd.emit;
      if (cmd.acc_clr) begin
        acc_r <= '0;
      end else if (prod_valid_r) begin
        acc_r <= acc_r + {{(dlm_pkg::ACC_W-dlm_pkg::PROD_W){prod_r[dlm_pkg::PROD_W-1]}},
                          prod_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= $signed(w_rdata) * $signed(x_rdata);
    if (cmd.emit) begin
      out_word_r <= out_word_nxt;
    end
  end

  // align bias, round half up, shift back, clip
  always_comb begin
    bias_ext = {{(dlm_pkg::ACC_W-dlm_pkg::VAL_W-dlm_pkg::FRAC_BITS){b_rdata[dlm_pkg::VAL_W-1]}},
                b_rdata, {dlm_pkg::FRAC_BITS{1'b0}}};
    total    = acc_r + bias_ext + dlm_pkg::ROUND_HALF;
    q        = total >>> dlm_pkg::FRAC_BITS;
    sat_hi   = (q > dlm_pkg::Q_MAX);
    sat_lo   = (q < dlm_pkg::Q_MIN);
    out_word_nxt.out_index = cmd.row;
    out_word_nxt.saturated = sat_hi || sat_lo;
    out_word_nxt.last      = cmd.last;
    priority if (sat_hi) begin
      out_word_nxt.out_value = {1'b0, {(dlm_pkg::VAL_W-1){1'b1}}};
    end else if (sat_lo) begin
      out_word_nxt.out_value = {1'b1, {(dlm_pkg::VAL_W-1){1'b0}}};
    end else begin
      out_word_nxt.out_value = q[dlm_pkg::VAL_W-1:0];
    end
  end

  assign stat.pipe_empty = !rd_valid_r && !prod_valid_r;
  assign out_valid       = out_valid_r;
  assign out_word        = out_word_r;

endmodule

// ===== hdl/dense_layer_matvec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_layer_matvec
// Fully connected layer forward pass, Q3.12 weights, inputs and biases.
//
//   channel  ports                        handshake
//   input    start, busy, in_word         taken when start && !busy
//   result   out_valid, out_word          one-cycle strobe, no back-pressure
//   config   cfg_we, cfg_index, cfg_data  taken when cfg_we
//
// Load words (weight, bias, input element) are taken one per cycle while busy is low.
// A run word holds busy while each row passes through row set-up, one MAC
// per cycle through the single weight RAM read port (none when in_size is
// zero), pipeline drain and result, with both sizes clipped to their maxima.
// Reset is synchronous; the stores hold no defined contents after it.
// Results are strobed and cannot be stalled.
// ----------------------------------------------------------------------------
module dense_layer_matvec (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  dlm_pkg::in_word_t               in_word,
  output logic                            out_valid,
  output dlm_pkg::out_word_t              out_word,
  input  logic                            cfg_we,
  input  logic [dlm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dlm_pkg::CFG_W-1:0]       cfg_data
);

  logic [dlm_pkg::IN_SIZE_W-1:0]  in_size_r;
  logic [dlm_pkg::OUT_SIZE_W-1:0] out_size_r;
  dlm_pkg::dp_cmd_t               cmd;
  dlm_pkg::dp_stat_t              stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_size_r  <= dlm_pkg::IN_SIZE_RST;
      out_size_r <= dlm_pkg::OUT_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dlm_pkg::CFG_IN_SIZE:  in_size_r  <= cfg_data[dlm_pkg::IN_SIZE_W-1:0];
        dlm_pkg::CFG_OUT_SIZE: out_size_r <= cfg_data[dlm_pkg::OUT_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  dlm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .command  (in_word.command),
    .in_size  (in_size_r),
    .out_size (out_size_r),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  dlm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

`ifndef NO_ASSERTIONS
  a_spaced_results: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results on consecutive cycles");

  a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.last) |-> busy)
    else $error("run ended before its last result");

  a_end_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> (out_valid && out_word.last))
    else $error("run ended without a last result");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cmd.load)
    else $error("store write during a run");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fully connected layer engine. Weight, bias and
// input words are loaded through the command port, run words are issued, and
// every strobed neuron result is compared with a fixed-point model of the
// layer (sum of products, bias alignment, round to nearest, saturation).
// Covers rounding ties, saturation at both rails, zero and oversized sizes,
// and random load/run traffic with random sender gaps.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT   = 200_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int ITEM_TARGET   = 120;

  logic                                clk       = 1'b0;
  logic                                rst_n     = 1'b0;
  logic                                start     = 1'b0;
  logic                                busy;
  dlm_pkg::in_word_t                   in_word   = '0;
  logic                                out_valid;
  dlm_pkg::out_word_t                  out_word;
  logic                                cfg_we    = 1'b0;
  logic [dlm_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [dlm_pkg::CFG_W-1:0]           cfg_data  = '0;

  logic signed [dlm_pkg::VAL_W-1:0] wt_mem   [dlm_pkg::W_DEPTH];
  logic signed [dlm_pkg::VAL_W-1:0] bias_mem [dlm_pkg::MAX_OUT];
  logic signed [dlm_pkg::VAL_W-1:0] x_mem    [dlm_pkg::MAX_IN];
  bit                               wt_set   [dlm_pkg::W_DEPTH];
  bit                               bias_set [dlm_pkg::MAX_OUT];
  bit                               x_set    [dlm_pkg::MAX_IN];
  logic [dlm_pkg::IN_SIZE_W-1:0]    in_size_r  = dlm_pkg::IN_SIZE_RST;
  logic [dlm_pkg::OUT_SIZE_W-1:0]   out_size_r = dlm_pkg::OUT_SIZE_RST;

  dlm_pkg::out_word_t pending_neurons [$];
  int                 errors      = 0;
  int                 cycle_count = 0;
  int                 burst_left  = 0;
  int                 items_sent  = 0;

  dense_layer_matvec u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int eff_in();
    return (in_size_r > dlm_pkg::MAX_IN) ? dlm_pkg::MAX_IN : int'(in_size_r);
  endfunction

  function automatic int eff_out();
    return (out_size_r > dlm_pkg::MAX_OUT) ? dlm_pkg::MAX_OUT : int'(out_size_r);
  endfunction

  function automatic logic signed [dlm_pkg::VAL_W-1:0] rand_q12();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3: return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 2047)) - 1024);
    endcase
  endfunction

  function automatic void predict_neurons();
    int                 n_in;
    int                 n_out;
    longint             acc;
    longint             q;
    dlm_pkg::out_word_t o;
    n_in  = eff_in();
    n_out = eff_out();
    for (int r = 0; r < n_out; r++) begin
      acc = 0;
      for (int c = 0; c < n_in; c++)
        acc += longint'(wt_mem[r * dlm_pkg::MAX_IN + c]) * longint'(x_mem[c]);
      acc += longint'(bias_mem[r]) <<< dlm_pkg::FRAC_BITS;
      q = (acc + (longint'(1) <<< (dlm_pkg::FRAC_BITS - 1))) >>> dlm_pkg::FRAC_BITS;
      o.saturated = 1'b0;
      if (q > 32767) begin
        q = 32767;
        o.saturated = 1'b1;
      end else if (q < -32768) begin
        q = -32768;
        o.saturated = 1'b1;
      end
      o.out_index = dlm_pkg::ROW_W'(r);
      o.out_value = dlm_pkg::VAL_W'(q);
      o.last      = (r == n_out - 1);
      pending_neurons.push_back(o);
    end
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_neuron(input dlm_pkg::out_word_t got);
    dlm_pkg::out_word_t want;
    if (pending_neurons.size() == 0) begin
      flag_error($sformatf("unexpected result word, row %0d", got.out_index));
      return;
    end
    want = pending_neurons.pop_front();
    if (got.out_index !== want.out_index)
      flag_error($sformatf("out_index got %0d want %0d", got.out_index, want.out_index));
    if (got.out_value !== want.out_value)
      flag_error($sformatf("row %0d out_value got %0d want %0d",
                           want.out_index, got.out_value, want.out_value));
    if (got.saturated !== want.saturated)
      flag_error($sformatf("row %0d saturated got %b want %b",
                           want.out_index, got.saturated, want.saturated));
    if (got.last !== want.last)
      flag_error($sformatf("row %0d last got %b want %b",
                           want.out_index, got.last, want.last));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid)
      check_neuron(out_word);
  end

  // hold start across a burst; drop it only for a gap
  task automatic send_word(input dlm_pkg::in_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    burst_left--;
    items_sent++;
    case (w.command)
      dlm_pkg::CMD_WEIGHT: begin
        wt_mem[{w.row, w.column}] = w.value;
        wt_set[{w.row, w.column}] = 1'b1;
      end
      dlm_pkg::CMD_BIAS: begin
        bias_mem[w.row] = w.value;
        bias_set[w.row] = 1'b1;
      end
      dlm_pkg::CMD_INPUT: begin
        x_mem[w.column] = w.value;
        x_set[w.column] = 1'b1;
      end
      dlm_pkg::CMD_RUN: predict_neurons();
    endcase
  endtask

  task automatic load_weight(input int r, input int c,
                             input logic signed [dlm_pkg::VAL_W-1:0] v);
    dlm_pkg::in_word_t w;
    w.command = dlm_pkg::CMD_WEIGHT;
    w.row     = dlm_pkg::ROW_W'(r);
    w.column  = dlm_pkg::COL_W'(c);
    w.value   = v;
    send_word(w);
  endtask

  task automatic load_bias(input int r, input logic signed [dlm_pkg::VAL_W-1:0] v);
    dlm_pkg::in_word_t w;
    w.command = dlm_pkg::CMD_BIAS;
    w.row     = dlm_pkg::ROW_W'(r);
    w.column  = dlm_pkg::COL_W'($urandom);
    w.value   = v;
    send_word(w);
  endtask

  task automatic load_input(input int c, input logic signed [dlm_pkg::VAL_W-1:0] v);
    dlm_pkg::in_word_t w;
    w.command = dlm_pkg::CMD_INPUT;
    w.row     = dlm_pkg::ROW_W'($urandom);
    w.column  = dlm_pkg::COL_W'(c);
    w.value   = v;
    send_word(w);
  endtask

  // load anything the next run would read that has never been written, then send the run word
  task automatic run_layer();
    dlm_pkg::in_word_t w;
    int                n_in;
    int                n_out;
    n_in  = eff_in();
    n_out = eff_out();
    for (int r = 0; r < n_out; r++)
      if (!bias_set[r]) load_bias(r, rand_q12());
    for (int c = 0; c < n_in; c++)
      if (!x_set[c]) load_input(c, rand_q12());
    for (int r = 0; r < n_out; r++)
      for (int c = 0; c < n_in; c++)
        if (!wt_set[r * dlm_pkg::MAX_IN + c]) load_weight(r, c, rand_q12());
    w.command = dlm_pkg::CMD_RUN;
    w.row     = dlm_pkg::ROW_W'($urandom);
    w.column  = dlm_pkg::COL_W'($urandom);
    w.value   = dlm_pkg::VAL_W'($urandom);
    send_word(w);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_neurons.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_sizes(input int n_in, input int n_out);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= dlm_pkg::CFG_IN_SIZE;
    cfg_data  <= dlm_pkg::CFG_W'(n_in);
    @(posedge clk);
    cfg_index <= dlm_pkg::CFG_OUT_SIZE;
    cfg_data  <= dlm_pkg::CFG_W'(n_out);
    @(posedge clk);
    cfg_we <= 1'b0;
    in_size_r  = dlm_pkg::IN_SIZE_W'(n_in);
    out_size_r = dlm_pkg::OUT_SIZE_W'(n_out);
  endtask

  task automatic test_rounding();
    set_sizes(1, 4);
    load_input(0, 16'sd2048);
    load_weight(0, 0, 16'sd1);
    load_weight(1, 0, -16'sd1);
    load_weight(2, 0, 16'sd3);
    load_weight(3, 0, -16'sd3);
    load_bias(0, 16'sd0);
    load_bias(1, 16'sd0);
    load_bias(2, -16'sd7);
    load_bias(3, 16'sd5);
    run_layer();
  endtask

  task automatic test_saturation();
    set_sizes(2, 4);
    load_input(0, 16'sh8000);
    load_input(1, 16'sh7FFF);
    load_weight(0, 0, 16'sh8000);
    load_weight(0, 1, 16'sh7FFF);
    load_weight(1, 0, 16'sh7FFF);
    load_weight(1, 1, 16'sh8000);
    load_weight(2, 0, 16'sd1);
    load_weight(2, 1, 16'sd0);
    load_weight(3, 0, 16'sd0);
    load_weight(3, 1, 16'sd0);
    load_bias(0, 16'sh7FFF);
    load_bias(1, 16'sh8000);
    load_bias(2, 16'sh7FFF);
    load_bias(3, 16'sh7FFF);
    run_layer();
  endtask

  task automatic test_size_limits();
    set_sizes(0, 3);
    run_layer();
    set_sizes(5, 0);
    run_layer();
    set_sizes(2047, 0);
    run_layer();
    set_sizes(0, 11'h7FF);
    run_layer();
  endtask

  task automatic send_random_load();
    int r;
    int c;
    if ($urandom_range(0, 3) == 0 || eff_out() == 0 || eff_in() == 0) begin
      r = $urandom_range(0, dlm_pkg::MAX_OUT - 1);
      c = $urandom_range(0, dlm_pkg::MAX_IN - 1);
    end else begin
      r = $urandom_range(0, eff_out() - 1);
      c = $urandom_range(0, eff_in() - 1);
    end
    case ($urandom_range(0, 2))
      0: load_weight(r, c, rand_q12());
      1: load_bias(r, rand_q12());
      default: load_input(c, rand_q12());
    endcase
  endtask

  task automatic test_random_traffic();
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 9))
          0: set_sizes($urandom_range(1025, 2047), 0);
          1: set_sizes(0, $urandom_range(65, 127));
          default: set_sizes($urandom_range(0, 4), $urandom_range(0, 4));
        endcase
      end else if ($urandom_range(0, 5) == 0) begin
        wait_idle();
      end
      repeat ($urandom_range(0, 6)) send_random_load();
      run_layer();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_rounding();
    test_saturation();
    test_size_limits();
    test_random_traffic();
    wait_idle();
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
